// ===== hw/rtl/cfra_pkg.sv =====
// Shared widths, a reset constant and control structs of the continued fraction approximator.
package cfra_pkg;

  localparam int XF_W   = 32;  // input fraction width
  localparam int TOL_W  = 32;  // tolerance register width
  localparam int NUM_W  = 32;  // numerator result width
  localparam int DEN_W  = 33;  // denominator result width
  localparam int ITER_W = 7;   // iteration count width

  localparam logic [TOL_W-1:0] TOL_RESET = 32'd4295;

  // Commands from the sequencer to the divider and the convergent unit
  typedef struct packed {
    logic init;    // load a new item
    logic start;   // begin one Euclidean division
    logic commit;  // close the step: shift pairs, take remainder
  } cfra_ctl_t;

  // Quotient bit stream, most significant bit first
  typedef struct packed {
    logic qvld;
    logic qbit;
    logic last;
  } cfra_qstr_t;

endpackage

// ===== hw/rtl/cfra_div.sv =====
// Shift-subtract divider that holds the Euclidean pair and streams quotient bits.
module cfra_div #(
  parameter int FRAC_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfra_pkg::cfra_ctl_t     ctl_i,
  input  logic [FRAC_BITS:0]      n_i,
  output logic [FRAC_BITS:0]      sc_o,
  output cfra_pkg::cfra_qstr_t    qstr_o
);
  import cfra_pkg::*;

  localparam int SW = FRAC_BITS + 1;
  localparam int CW = $clog2(SW);

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_NORM,
    DV_QUOT
  } dv_state_e;

  dv_state_e         state_q, state_d;
  cfra_qstr_t        qstr_q, qstr_d;
  logic [SW-1:0]     sp_q, sc_q, rem_q, dv_q;
  logic [CW-1:0]     cnt_q;
  logic              shift_ok, sub_ok;

  // Divisor may still double without passing the partial remainder
  assign shift_ok = {dv_q, 1'b0} <= {1'b0, rem_q};
  assign sub_ok   = rem_q >= dv_q;

  always_comb begin
    state_d = state_q;
    qstr_d  = '0;
    unique case (state_q)
      DV_IDLE: begin
        if (ctl_i.start) state_d = DV_NORM;
      end
      DV_NORM: begin
        if (!shift_ok) state_d = DV_QUOT;
      end
      DV_QUOT: begin
        qstr_d.qvld = 1'b1;
        qstr_d.qbit = sub_ok;
        if (cnt_q == '0) begin
          qstr_d.last = 1'b1;
          state_d     = DV_IDLE;
        end
      end
      default: state_d = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      qstr_q  <= '0;
    end else begin
      state_q <= state_d;
      qstr_q  <= qstr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.init) begin
      sp_q <= {1'b1, {FRAC_BITS{1'b0}}};
      sc_q <= n_i;
    end else if (ctl_i.commit) begin
      sp_q <= sc_q;
      sc_q <= rem_q;
    end
    if (state_q == DV_IDLE && ctl_i.start) begin
      rem_q <= sp_q;
      dv_q  <= sc_q;
      cnt_q <= '0;
    end else if (state_q == DV_NORM && shift_ok) begin
      dv_q  <= {dv_q[SW-2:0], 1'b0};
      cnt_q <= cnt_q + 1'b1;
    end else if (state_q == DV_QUOT) begin
      if (sub_ok) rem_q <= rem_q - dv_q;
      dv_q <= {1'b0, dv_q[SW-1:1]};
      if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
    end
  end

  assign sc_o   = sc_q;
  assign qstr_o = qstr_q;

`ifndef SYNTH
  a_norm_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == DV_NORM |-> dv_q <= rem_q)
    else $error("divisor passed partial remainder");
  a_rem_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstr_q.last |-> rem_q < sc_q)
    else $error("remainder not below divisor at end of division");
`endif

endmodule

// ===== hw/rtl/cfra_mac.sv =====
// Convergent recurrences for A, B and tolerance*B, built by Horner steps over quotient bits.
module cfra_mac #(
  parameter int FRAC_BITS = 32
) (
  input  logic                                  clk_i,
  input  cfra_pkg::cfra_ctl_t                   ctl_i,
  input  cfra_pkg::cfra_qstr_t                  qstr_i,
  input  logic [cfra_pkg::TOL_W-1:0]            tol_i,
  output logic [FRAC_BITS-1:0]                  a_o,
  output logic [FRAC_BITS:0]                    b_o,
  output logic [FRAC_BITS+cfra_pkg::TOL_W-1:0]  p_o
);
  import cfra_pkg::*;

  localparam int AW = FRAC_BITS;
  localparam int BW = FRAC_BITS + 1;
  localparam int PW = FRAC_BITS + TOL_W;

  logic [AW-1:0] a_q, am1_q, acc_a_q;
  logic [BW-1:0] b_q, bm1_q, acc_b_q;
  logic [PW-1:0] p_q, pm1_q, acc_p_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.init) begin
      am1_q <= AW'(1);
      a_q   <= '0;
      bm1_q <= '0;
      b_q   <= BW'(1);
      pm1_q <= '0;
      p_q   <= PW'(tol_i);
    end else if (ctl_i.commit) begin
      // close q*X + X[k-2], advance the pairs
      a_q   <= acc_a_q + am1_q;
      am1_q <= a_q;
      b_q   <= acc_b_q + bm1_q;
      bm1_q <= b_q;
      p_q   <= acc_p_q + pm1_q;
      pm1_q <= p_q;
    end
    if (ctl_i.start) begin
      acc_a_q <= '0;
      acc_b_q <= '0;
      acc_p_q <= '0;
    end else if (qstr_i.qvld) begin
      acc_a_q <= {acc_a_q[AW-2:0], 1'b0} + (qstr_i.qbit ? a_q : '0);
      acc_b_q <= {acc_b_q[BW-2:0], 1'b0} + (qstr_i.qbit ? b_q : '0);
      acc_p_q <= {acc_p_q[PW-2:0], 1'b0} + (qstr_i.qbit ? p_q : '0);
    end
  end

  assign a_o = a_q;
  assign b_o = b_q;
  assign p_o = p_q;

endmodule

// ===== hw/rtl/continued_fraction_rational_approx.sv =====
// Continued fraction best rational approximation of an unsigned fixed-point fraction.
// The sum of the quotient bit lengths over K partial quotients q_k is bounded by FRAC_BITS + K.
// Throughput: one item at a time; the shift-subtract divider, one quotient bit per cycle,
//   sets the rate. A new item is taken while the previous result waits in the output register.
// Reset: asynchronous, active low; clears control state, tolerance returns to 4295.
module continued_fraction_rational_approx #(
  parameter int FRAC_BITS = 32,
  parameter int MAX_ITER  = 100
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write
  input  logic                          cfg_wen_i,
  input  logic [cfra_pkg::TOL_W-1:0]    cfg_wdata_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [cfra_pkg::XF_W-1:0]     x_fraction_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [cfra_pkg::NUM_W-1:0]    numerator_o,
  output logic [cfra_pkg::DEN_W-1:0]    denominator_o,
  output logic [cfra_pkg::ITER_W-1:0]   iterations_o
);
  import cfra_pkg::*;

  localparam int SW       = FRAC_BITS + 1;
  localparam int PW       = FRAC_BITS + TOL_W;
  localparam int XW       = (FRAC_BITS < XF_W) ? FRAC_BITS : XF_W;
  localparam int ITER_SAT = (1 << ITER_W) - 1;
  localparam logic [ITER_W-1:0] K_MAX  = ITER_W'(MAX_ITER);
  localparam logic [ITER_W-1:0] K_FAIL =
    ITER_W'((MAX_ITER + 1 > ITER_SAT) ? ITER_SAT : MAX_ITER + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_DIV,
    ST_UPDATE,
    ST_FIN
  } state_e;

  state_e              state_q, state_d;
  logic [ITER_W-1:0]   k_q, k_d;
  logic                done_q, done_d;
  logic                out_valid_q, out_valid_d;
  logic [TOL_W-1:0]    tol_q;
  logic [NUM_W-1:0]    num_q;
  logic [DEN_W-1:0]    den_q;
  logic [ITER_W-1:0]   iter_q;

  cfra_ctl_t           ctl;
  cfra_qstr_t          qstr;
  logic [SW-1:0]       n_w, sc_w;
  logic [FRAC_BITS-1:0] a_w;
  logic [SW-1:0]       b_w;
  logic [PW-1:0]       p_w;
  logic                sc_le_p, out_free;

  // Only the fraction bits count: the input is taken modulo one
  assign n_w = SW'(x_fraction_i[XW-1:0]);

  // Tolerance register, to be written only while idle; the block itself does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_wen_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  cfra_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .n_i    (n_w),
    .sc_o   (sc_w),
    .qstr_o (qstr)
  );

  cfra_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .qstr_i (qstr),
    .tol_i  (tol_q),
    .a_o    (a_w),
    .b_o    (b_w),
    .p_o    (p_w)
  );

  // The Euclidean remainder equals |N*B - A*2^F|, and p_w tracks tolerance*B exactly,
  // so the error test is a single compare. A zero remainder always passes here.
  assign sc_le_p  = {{(PW - SW){1'b0}}, sc_w} <= p_w;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    done_d      = done_q;
    ctl         = '0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctl.init = 1'b1;
          k_d      = '0;
          state_d  = ST_TEST;
        end
      end
      ST_TEST: begin
        priority if (sc_le_p) begin
          done_d  = 1'b1;
          state_d = ST_FIN;
        end else if (k_q >= K_MAX) begin
          done_d  = 1'b0;
          state_d = ST_FIN;
        end else begin
          ctl.start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        // hold until the last quotient bit has reached the accumulators
        if (qstr.last) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        ctl.commit = 1'b1;
        k_d        = k_q + 1'b1;
        state_d    = ST_TEST;
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result register: load when the slot is empty or being drained
  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN && out_free) begin
      num_q  <= NUM_W'(a_w);
      den_q  <= DEN_W'(b_w);
      iter_q <= done_q ? k_q : K_FAIL;
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign numerator_o   = num_q;
  assign denominator_o = den_q;
  assign iterations_o  = iter_q;

`ifndef SYNTH
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV || state_q == ST_UPDATE) |-> sc_w != '0)
    else $error("division started with zero divisor");
  a_k_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPDATE |=> k_q == $past(k_q) + 1'b1)
    else $error("convergent index did not advance");
  a_iter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> iterations_o <= K_FAIL)
    else $error("iteration count out of range");
`endif

endmodule
